>>> src/assert_macros.svh
// Assertion macros used by the codec top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/bvc_pkg.sv
// Types and constants for the base-128 varint codec.
package bvc_pkg;

  localparam int unsigned ValueW = 64;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned DigitW = 7;
  localparam int unsigned PosW   = 4;
  localparam int unsigned ShiftW = 6;

  localparam logic [DigitW-1:0] DigitMask = 7'h7f;
  localparam logic [PosW-1:0]   LastPos   = 4'd9;
  localparam logic [PosW-1:0]   LastCount = 4'd9;

  // Input mode codes.
  localparam logic ModeEncode = 1'b0;
  localparam logic ModeDecode = 1'b1;

  // Result kind codes.
  localparam logic KindByte  = 1'b0;
  localparam logic KindValue = 1'b1;

  // One classified word in the front-to-back queue. Decode words carry the
  // input byte in the low bits of payload.
  typedef struct packed {
    logic              is_decode;
    logic [ValueW-1:0] payload;
  } bvc_item_t;

  // Back-end status seen by the top level.
  typedef struct packed {
    logic enc_busy;
    logic advance;
    logic enc_stop;
    logic q_pop;
  } bvc_back_status_t;

endpackage

>>> src/bvc_front.sv
// Front end: accepts input words, classifies them and queues them for the back end.
module bvc_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      mode_i,
  input  logic [63:0]               value_in_i,
  input  logic [7:0]                byte_in_i,
  output logic                      q_valid_o,
  input  logic                      q_ready_i,
  output bvc_pkg::bvc_item_t        q_item_o
);
  import bvc_pkg::*;

  bvc_item_t  mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;
  bvc_item_t  item_in;

  assign in_ready_o = (count_q != 2'd2);
  assign q_valid_o  = (count_q != 2'd0);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  always_comb begin
    item_in.is_decode = (mode_i == ModeDecode);
    item_in.payload   = (mode_i == ModeDecode) ? {{(ValueW-ByteW){1'b0}}, byte_in_i}
                                               : value_in_i;
  end

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

  assign q_item_o = mem_q[rd_ptr_q];

endmodule

>>> src/bvc_back.sv
// Back end: runs the encode byte emitter and the decode accumulator into an output register.
module bvc_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_valid_i,
  output logic                      q_ready_o,
  input  bvc_pkg::bvc_item_t        q_item_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      kind_o,
  output logic [7:0]                byte_out_o,
  output logic [63:0]               value_out_o,
  output logic                      last_o,
  output bvc_pkg::bvc_back_status_t status_o
);
  import bvc_pkg::*;

  // encode state
  logic              enc_busy_q, enc_busy_d;
  logic [ValueW-1:0] n_q, n_d;
  logic [PosW-1:0]   cnt_q, cnt_d;
  // decode state
  logic [ValueW-1:0] sum_q, sum_d;
  logic [PosW-1:0]   pos_q, pos_d;
  // output register
  logic              out_valid_q, out_valid_d;
  logic              kind_q, kind_d;
  logic [ByteW-1:0]  byte_q, byte_d;
  logic [ValueW-1:0] value_q, value_d;
  logic              last_q, last_d;

  logic              advance;
  logic              q_pop;
  logic [ValueW-1:0] enc_src;
  logic [PosW-1:0]   cnt_src;
  logic              more;
  logic              enc_stop;
  logic [ValueW-1:0] n_next;
  logic [ByteW-1:0]  dec_byte;
  logic [PosW-1:0]   pos_c;
  logic [ShiftW-1:0] sh;
  logic [ByteW-1:0]  digit;
  logic [ValueW-1:0] sum_new;
  logic              dec_end;

  assign advance   = !out_valid_q || out_ready_i;
  assign q_ready_o = advance && !enc_busy_q;
  assign q_pop     = q_ready_o && q_valid_i;

  // byte emitter, shared by the first and the following bytes of an encoding
  assign enc_src  = enc_busy_q ? n_q : q_item_i.payload;
  assign cnt_src  = enc_busy_q ? cnt_q : '0;
  assign more     = |enc_src[ValueW-1:DigitW];
  assign enc_stop = !more || (cnt_src == LastCount);
  assign n_next   = (enc_src >> DigitW) - {{(ValueW-1){1'b0}}, 1'b1};

  // decode accumulator
  assign dec_byte = q_item_i.payload[ByteW-1:0];
  assign pos_c    = (pos_q > LastPos) ? LastPos : pos_q;
  assign sh       = ShiftW'(pos_c) * ShiftW'(DigitW);
  assign digit    = {1'b0, dec_byte[DigitW-1:0]} + {{(ByteW-1){1'b0}}, (pos_q != '0)};
  assign sum_new  = sum_q + ({{(ValueW-ByteW){1'b0}}, digit} << sh);
  assign dec_end  = !dec_byte[ByteW-1] || (pos_q >= LastPos);

  always_comb begin
    enc_busy_d  = enc_busy_q;
    n_d         = n_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    byte_d      = byte_q;
    value_d     = value_q;
    last_d      = last_q;
    if (advance) begin
      out_valid_d = 1'b0;
      if (enc_busy_q || (q_pop && !q_item_i.is_decode)) begin
        out_valid_d = 1'b1;
        kind_d      = KindByte;
        byte_d      = {more, enc_src[DigitW-1:0] & DigitMask};
        value_d     = '0;
        last_d      = !more;
        enc_busy_d  = !enc_stop;
        n_d         = n_next;
        cnt_d       = cnt_src + PosW'(1);
      end else if (q_pop) begin
        if (dec_end) begin
          out_valid_d = 1'b1;
          kind_d      = KindValue;
          byte_d      = '0;
          value_d     = sum_new;
          last_d      = 1'b1;
          sum_d       = '0;
          pos_d       = '0;
        end else begin
          sum_d = sum_new;
          pos_d = pos_q + PosW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_busy_q  <= 1'b0;
      cnt_q       <= '0;
      sum_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      enc_busy_q  <= enc_busy_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    kind_q  <= kind_d;
    byte_q  <= byte_d;
    value_q <= value_d;
    last_q  <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign byte_out_o  = byte_q;
  assign value_out_o = value_q;
  assign last_o      = last_q;

  always_comb begin
    status_o.enc_busy = enc_busy_q;
    status_o.advance  = advance;
    status_o.enc_stop = enc_stop;
    status_o.q_pop    = q_pop;
  end

endmodule

>>> src/base128_varint_codec_unit.sv
// Top level of the bijective base-128 varint encoder/decoder.
`include "assert_macros.svh"

// Each input word is either an encode request (mode 0, 64-bit value_in) or one
// byte of an encoded stream to decode (mode 1, byte_in). Encoding a value
// produces 1 to 10 byte words, least significant digit first, bit 7 set on
// all but the last; the back end's byte emitter sends one byte per cycle while
// the output register can advance. Decoding takes one byte per cycle under the
// same condition and returns a single 64-bit value word (last set) once a byte
// below 128 or the tenth byte arrives; earlier bytes return nothing. An encode
// word between decode bytes leaves the pending decode untouched. A two-word
// queue sits between the input side and the back end, and results leave through
// an output register, so the queue takes input while a result waits, till full.
module base128_varint_codec_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [63:0] value_in_i,
  input  logic [7:0]  byte_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [7:0]  byte_out_o,
  output logic [63:0] value_out_o,
  output logic        last_o
);
  import bvc_pkg::*;

  logic             q_valid;
  logic             q_ready;
  bvc_item_t        q_item;
  bvc_back_status_t status;

  bvc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_i),
    .value_in_i (value_in_i),
    .byte_in_i  (byte_in_i),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_item_o   (q_item)
  );

  bvc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_item_i    (q_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .byte_out_o  (byte_out_o),
    .value_out_o (value_out_o),
    .last_o      (last_o),
    .status_o    (status)
  );

  `ASSERT_IMPL(a_no_pop_while_encoding, status.enc_busy, !status.q_pop, "queue popped mid-encode")
  `ASSERT_NEXT(a_encode_continues, status.enc_busy && status.advance && !status.enc_stop, status.enc_busy, "encode ended early")
  `ASSERT_IMPL(a_value_is_last, out_valid_o && (kind_o == KindValue), last_o && (byte_out_o == '0), "bad value word")
  `ASSERT_IMPL(a_last_byte_final, out_valid_o && (kind_o == KindByte) && last_o, !byte_out_o[7], "last byte has continuation")

endmodule

>>> tb/base128_varint_codec_unit_test.sv
// Self-checking testbench for the base-128 varint codec unit.
`timescale 1ns / 100ps

module base128_varint_codec_unit_test;
  import bvc_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int LongHold   = 200;
  localparam int TailCycles = 20;
  localparam int TotalItems = 150;

  typedef struct packed {
    logic        kind;
    logic [7:0]  dout;
    logic [63:0] vout;
    logic        last;
  } codec_result_t;

  typedef struct packed {
    logic          mode;
    logic [63:0]   vin;
    logic [7:0]    din;
    logic          typed;
    codec_result_t want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        mode_i = ModeEncode;
  logic [63:0] value_in_i = '0;
  logic [7:0]  byte_in_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        kind_o;
  logic [7:0]  byte_out_o;
  logic [63:0] value_out_o;
  logic        last_o;

  base128_varint_codec_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .value_in_i  (value_in_i),
    .byte_in_i   (byte_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .byte_out_o  (byte_out_o),
    .value_out_o (value_out_o),
    .last_o      (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Decoder state mirror.
  logic [63:0] dec_sum = '0;
  logic [3:0]  dec_pos = '0;

  codec_result_t pending_results[$];
  int  err_count = 0;
  int  words_sent = 0;
  int  quiet_cycles = 0;
  int  ready_hold = 0;
  bit  idle_on = 1'b1;
  bit  long_hold_req = 1'b0;
  codec_result_t got;
  codec_result_t want;

  // Directed words; typed rows carry a result readable at a glance.
  stim_row_t directed_rows [0:22] = '{
    '{ModeDecode, 64'd0, 8'h00, 1'b1, '{KindValue, 8'h00, 64'd0,   1'b1}},
    '{ModeDecode, 64'd0, 8'h7f, 1'b1, '{KindValue, 8'h00, 64'd127, 1'b1}},
    '{ModeEncode, 64'd0, 8'hff, 1'b1, '{KindByte,  8'h00, 64'd0,   1'b1}},
    '{ModeEncode, 64'd127, 8'h00, 1'b1, '{KindByte, 8'h7f, 64'd0,  1'b1}},
    '{ModeEncode, 64'd128, 8'h00, 1'b0, '0},
    '{ModeEncode, 64'hffff_ffff_ffff_ffff, 8'h00, 1'b0, '0},
    '{ModeEncode, 64'h8000_0000_0000_0000, 8'h00, 1'b0, '0},
    '{ModeDecode, 64'd0, 8'h80, 1'b0, '0},
    '{ModeDecode, 64'd0, 8'h00, 1'b0, '0},
    '{ModeDecode, 64'd0, 8'hff, 1'b0, '0},
    '{ModeEncode, 64'd16383, 8'h00, 1'b0, '0},  // encode in the middle of a decode
    '{ModeDecode, 64'd0, 8'h7f, 1'b0, '0},
    // ten continuation bytes: the tenth ends the value, sum wraps
    '{ModeDecode, 64'd0, 8'hff, 1'b0, '0},
    '{ModeDecode, 64'd0, 8'hff, 1'b0, '0},
    '{ModeDecode, 64'd0, 8'hff, 1'b0, '0},
    '{ModeDecode, 64'd0, 8'hff, 1'b0, '0},
    '{ModeDecode, 64'd0, 8'hff, 1'b0, '0},
    '{ModeDecode, 64'd0, 8'hff, 1'b0, '0},
    '{ModeDecode, 64'd0, 8'hff, 1'b0, '0},
    '{ModeDecode, 64'd0, 8'hff, 1'b0, '0},
    '{ModeDecode, 64'd0, 8'hff, 1'b0, '0},
    '{ModeDecode, 64'd0, 8'hff, 1'b0, '0},
    '{ModeEncode, 64'h0123_4567_89ab_cdef, 8'h00, 1'b0, '0}
  };

  // Bijective base-128 digits, least significant first.
  function automatic void varint_encode(input logic [63:0] v, output logic [7:0] bytes[$]);
    logic [63:0] n;
    bit more;
    n = v;
    bytes = {};
    forever begin
      more = n > 64'd127;
      bytes.insert(bytes.size(), {more, n[6:0]});
      if (!more || bytes.size() >= 10) break;
      n = (n >> 7) - 64'd1;
    end
  endfunction

  function automatic void predict_codec_results(input logic m, input logic [63:0] v,
                                                input logic [7:0] b,
                                                output codec_result_t res[$]);
    logic [7:0]    bytes[$];
    logic [63:0]   weight;
    logic [63:0]   digit;
    int            sh;
    codec_result_t one;
    res = {};
    if (m == ModeEncode) begin
      varint_encode(v, bytes);
      foreach (bytes[i]) begin
        one = '{KindByte, bytes[i], 64'd0, i == bytes.size() - 1};
        res.insert(res.size(), one);
      end
    end else begin
      sh = (dec_pos <= LastPos) ? 7 * int'(dec_pos) : 7 * int'(LastPos);
      weight = 64'd1 << sh;
      digit = {57'd0, b[6:0]} + ((dec_pos != 0) ? 64'd1 : 64'd0);
      dec_sum = dec_sum + weight * digit;
      if (!b[7] || dec_pos >= LastPos) begin
        one = '{KindValue, 8'h00, dec_sum, 1'b1};
        res.insert(res.size(), one);
        dec_sum = '0;
        dec_pos = '0;
      end else begin
        dec_pos = dec_pos + 4'd1;
      end
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [63:0] rand_value();
    case ($urandom_range(0, 9))
      0: return '1;
      1: return 64'd0;
      default: return {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
  endfunction

  task automatic send_word(input logic m, input logic [63:0] v, input logic [7:0] b,
                           output codec_result_t res[$]);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= m;
    value_in_i <= v;
    byte_in_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    predict_codec_results(m, v, b, res);
    foreach (res[i]) pending_results.insert(pending_results.size(), res[i]);
    words_sent++;
  endtask

  task automatic send_encode(input logic [63:0] v);
    codec_result_t res[$];
    send_word(ModeEncode, v, 8'($urandom), res);
  endtask

  task automatic send_decode(input logic [7:0] b);
    codec_result_t res[$];
    send_word(ModeDecode, {$urandom, $urandom}, b, res);
  endtask

  // Only drops valid when it has to wait, so the next word can follow in this step.
  task automatic drain_results();
    if (pending_results.size() != 0) begin
      in_valid_i <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk_i);
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      err_count++;
    end
  endtask

  // Receiver: random stalls plus one long hold-off on request.
  always @(posedge clk_i) begin
    if (ready_hold == 0) begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        ready_hold = LongHold;
      end else begin
        ready_hold = pick_gap();
      end
    end
    if (ready_hold > 0) begin
      ready_hold--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{kind_o, byte_out_o, value_out_o, last_o};
      if (pending_results.size() == 0) begin
        $error("unexpected result word: kind %0d byte 0x%0h value 0x%0h last %0d",
               kind_o, byte_out_o, value_out_o, last_o);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", want.kind, got.kind);
        check_field("byte_out", want.dout, got.dout);
        check_field("value_out", want.vout, got.vout);
        check_field("last", want.last, got.last);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("base128_varint_codec_unit_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    codec_result_t res[$];
    logic [7:0]    seq[$];
    int            r;
    int            cut;
    int            mid;
    bit            hold_done;
    bit            pause_done;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].mode, directed_rows[i].vin, directed_rows[i].din, res);
      if (directed_rows[i].typed && (res.size() != 1 || res[0] !== directed_rows[i].want)) begin
        $error("directed row %0d: prediction disagrees with the typed result", i);
        err_count++;
      end
    end
    drain_results();

    while (words_sent < TotalItems) begin
      // one long receiver hold-off while words keep coming, one full pause,
      // and a stretch with no gaps on either side
      if (!hold_done && words_sent >= 60) begin
        long_hold_req = 1'b1;
        hold_done = 1'b1;
      end
      if (!pause_done && words_sent >= 100) begin
        drain_results();
        pause_done = 1'b1;
      end
      idle_on = !(words_sent >= 120 && words_sent < 150);

      r = $urandom_range(0, 99);
      if (r < 35) begin
        send_encode(rand_value());
      end else if (r < 80) begin
        varint_encode(rand_value(), seq);
        // broken sequences: drop the terminating byte now and then
        cut = ($urandom_range(0, 9) == 0 && seq.size() > 1) ? seq.size() - 1 : seq.size();
        mid = ($urandom_range(0, 4) == 0) ? $urandom_range(0, cut - 1) : -1;
        for (int k = 0; k < cut; k++) begin
          if (k == mid) send_encode(rand_value());
          send_decode(seq[k]);
        end
      end else if (r < 90) begin
        // run of continuation bytes: the tenth byte of the pending value closes it
        repeat (10) send_decode(8'($urandom) | 8'h80);
      end else begin
        repeat ($urandom_range(1, 4)) send_decode(8'($urandom));
      end
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (err_count == 0)
      $display("base128_varint_codec_unit_test: clean");
    else
      $display("base128_varint_codec_unit_test: errors");
    $finish;
  end

endmodule
